// ----- src/tcpq_pkg.sv -----
// Package for the two-class priority queue core.
// Holds depth and width constants, action and status codes.
// No dependencies.
`default_nettype none

package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TICKET_BITS = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_NORMAL   = 3'd0,
        ACT_ADD_PRIORITY = 3'd1,
        ACT_SERVE        = 3'd2,
        ACT_LIST_NORMAL  = 3'd3,
        ACT_LIST_PRIO    = 3'd4,
        ACT_LIST_BOTH    = 3'd5,
        ACT_CLEAR        = 3'd6,
        ACT_UNUSED       = 3'd7
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 3'd0,
        ST_SERVED   = 3'd1,
        ST_LISTED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    localparam logic CLS_NORMAL   = 1'b0;
    localparam logic CLS_PRIORITY = 1'b1;

endpackage

`default_nettype wire

// ----- src/two_class_priority_queue_core.sv -----
// Two-class strict priority ticket queue: normal and priority FIFOs in
// on-chip arrays, one index adder shared by all pointer arithmetic.
// Depends on tcpq_pkg.
`default_nettype none

// Usage: each input beat carries an action in tuser and a ticket in tdata.
// Add, clear, the unused action and a serve that finds both queues empty are
// completed at issue. Any other serve steps through issue, a registered memory
// read and the result. Listing steps through issue, then per queue an empty
// check and, per entry, a read and a result; list both covers the priority
// queue first, then normal.
// Each entry read and every head/tail index goes through a single
// wrap-around adder under a four-state sequencer. Input is not taken while
// a serve or list is in progress, nor while a result waits in the output
// register with m_axis_tready low; each such stall lengthens the steps
// above. Clear and the unused action yield no result.
module two_class_priority_queue_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [tcpq_pkg::TICKET_BITS-1:0]  s_axis_tdata,  // [15:0] ticket
    input  wire  [tcpq_pkg::ACTION_W-1:0]     s_axis_tuser,  // [2:0] action
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [tcpq_pkg::TICKET_BITS-1:0]  m_axis_tdata,  // [15:0] ticket_out
    output logic [tcpq_pkg::STATUS_W:0]       m_axis_tuser,  // [2:0] status, [3] queue_class
    output logic                              m_axis_tlast
);
    import tcpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_FETCH = 4'b0100,
        S_LOAD  = 4'b1000
    } t_state;

    localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [TICKET_BITS-1:0] mem_n [QUEUE_DEPTH];
    logic [TICKET_BITS-1:0] mem_p [QUEUE_DEPTH];

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_head_n, n_head_n, r_head_p, n_head_p;
    logic [CNT_W-1:0]       r_cnt_n, n_cnt_n, r_cnt_p, n_cnt_p;
    logic                   r_cls, n_cls;
    logic                   r_both, n_both;
    logic                   r_serve, n_serve;
    logic [CNT_W-1:0]       r_i, n_i;
    logic                   r_out_valid, n_out_valid;
    logic [TICKET_BITS-1:0] r_rd;
    t_status                r_status, n_status;
    logic [TICKET_BITS-1:0] r_ticket, n_ticket;
    logic                   r_qcls, n_qcls;
    logic                   r_last, n_last;

    logic                   out_free;
    logic                   in_beat;
    logic                   add_cls;
    logic [IDX_W-1:0]       sel_head;
    logic [CNT_W-1:0]       sel_cnt;
    logic [CNT_W-1:0]       add_cnt;
    logic                   both_more;
    logic [CNT_W-1:0]       i_next;
    logic                   load;
    logic                   wr_n, wr_p;

    // shared wrap-around index unit
    logic [IDX_W-1:0]       alu_a;
    logic [CNT_W-1:0]       alu_b;
    logic [CNT_W:0]         alu_sum;
    logic [IDX_W-1:0]       alu_idx;

    assign alu_sum = (CNT_W + 1)'(alu_a) + (CNT_W + 1)'(alu_b);
    assign alu_idx = (alu_sum >= DEPTH_S) ? IDX_W'(alu_sum - DEPTH_S) : IDX_W'(alu_sum);

    assign out_free  = !r_out_valid || m_axis_tready;
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign add_cls   = s_axis_tuser[0];
    assign sel_head  = r_cls ? r_head_p : r_head_n;
    assign sel_cnt   = r_cls ? r_cnt_p : r_cnt_n;
    assign add_cnt   = add_cls ? r_cnt_p : r_cnt_n;
    assign both_more = r_both && r_cls;
    assign i_next    = r_i + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_head_n    = r_head_n;
        n_head_p    = r_head_p;
        n_cnt_n     = r_cnt_n;
        n_cnt_p     = r_cnt_p;
        n_cls       = r_cls;
        n_both      = r_both;
        n_serve     = r_serve;
        n_i         = r_i;
        n_status    = r_status;
        n_ticket    = r_ticket;
        n_qcls      = r_qcls;
        n_last      = r_last;
        load        = 1'b0;
        wr_n        = 1'b0;
        wr_p        = 1'b0;
        alu_a       = sel_head;
        alu_b       = r_i;
        s_axis_tready = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = out_free;
                alu_a = add_cls ? r_head_p : r_head_n;
                alu_b = add_cnt;
                if (in_beat) begin
                    case (t_action'(s_axis_tuser))
                        ACT_ADD_NORMAL, ACT_ADD_PRIORITY: begin
                            load     = 1'b1;
                            n_ticket = '0;
                            n_qcls   = add_cls;
                            n_last   = 1'b1;
                            if (add_cnt == DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_ENQUEUED;
                                if (add_cls) begin
                                    wr_p    = 1'b1;
                                    n_cnt_p = r_cnt_p + CNT_W'(1);
                                end else begin
                                    wr_n    = 1'b1;
                                    n_cnt_n = r_cnt_n + CNT_W'(1);
                                end
                            end
                        end
                        ACT_SERVE: begin
                            n_serve = 1'b1;
                            n_both  = 1'b0;
                            n_i     = '0;
                            if (r_cnt_p != '0) begin
                                n_cls   = CLS_PRIORITY;
                                n_state = S_FETCH;
                            end else if (r_cnt_n != '0) begin
                                n_cls   = CLS_NORMAL;
                                n_state = S_FETCH;
                            end else begin
                                load     = 1'b1;
                                n_status = ST_EMPTY;
                                n_ticket = '0;
                                n_qcls   = CLS_NORMAL;
                                n_last   = 1'b1;
                            end
                        end
                        ACT_LIST_NORMAL, ACT_LIST_PRIO, ACT_LIST_BOTH: begin
                            n_serve = 1'b0;
                            n_i     = '0;
                            n_cls   = (t_action'(s_axis_tuser) != ACT_LIST_NORMAL);
                            n_both  = (t_action'(s_axis_tuser) == ACT_LIST_BOTH);
                            n_state = S_CHECK;
                        end
                        ACT_CLEAR: begin
                            n_head_n = '0;
                            n_head_p = '0;
                            n_cnt_n  = '0;
                            n_cnt_p  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (sel_cnt != '0) begin
                    n_state = S_FETCH;
                end else if (out_free) begin
                    load     = 1'b1;
                    n_status = ST_EMPTY;
                    n_ticket = '0;
                    n_qcls   = r_cls;
                    n_last   = !both_more;
                    if (both_more) begin
                        n_cls = CLS_NORMAL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_serve) begin
                    alu_b = CNT_W'(1);
                end
                if (out_free) begin
                    load     = 1'b1;
                    n_ticket = r_rd;
                    n_qcls   = r_cls;
                    if (r_serve) begin
                        n_status = ST_SERVED;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                        if (r_cls) begin
                            n_head_p = alu_idx;
                            n_cnt_p  = r_cnt_p - CNT_W'(1);
                        end else begin
                            n_head_n = alu_idx;
                            n_cnt_n  = r_cnt_n - CNT_W'(1);
                        end
                    end else begin
                        n_status = ST_LISTED;
                        n_last   = (i_next == sel_cnt) && !both_more;
                        n_i      = i_next;
                        if (i_next < sel_cnt) begin
                            n_state = S_FETCH;
                        end else if (both_more) begin
                            n_cls   = CLS_NORMAL;
                            n_i     = '0;
                            n_state = S_CHECK;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = load || (r_out_valid && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_n    <= '0;
            r_head_p    <= '0;
            r_cnt_n     <= '0;
            r_cnt_p     <= '0;
            r_cls       <= 1'b0;
            r_both      <= 1'b0;
            r_serve     <= 1'b0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head_n    <= n_head_n;
            r_head_p    <= n_head_p;
            r_cnt_n     <= n_cnt_n;
            r_cnt_p     <= n_cnt_p;
            r_cls       <= n_cls;
            r_both      <= n_both;
            r_serve     <= n_serve;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ticket <= n_ticket;
        r_qcls   <= n_qcls;
        r_last   <= n_last;
    end

    // ticket stores, registered read
    always_ff @(posedge i_clk) begin
        if (wr_n) begin
            mem_n[alu_idx] <= s_axis_tdata;
        end
        if (wr_p) begin
            mem_p[alu_idx] <= s_axis_tdata;
        end
        if (r_state == S_FETCH) begin
            r_rd <= r_cls ? mem_p[alu_idx] : mem_n[alu_idx];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_ticket;
    assign m_axis_tuser  = {r_qcls, r_status};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire
